// File: rtl/rrfs_pkg.sv
// Shared constants and types for the round-robin frame segmenter.
package rrfs_pkg;

	localparam int STREAMS_DEF = 4;
	localparam int ROUNDS_DEF  = 8;
	localparam int NUM_IDS     = 4;
	localparam int STREAM_W    = 2;
	localparam int ADDR_W      = 32;
	localparam int LEN_W       = 16;
	localparam int NODE_W      = 8;
	localparam int CNT_W       = 4;
	localparam int FRAME_MAX   = 8;
	localparam int CFG_IDX_W   = 8;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 48;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NETWORK_ID_0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NETWORK_ID_1 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_NETWORK_ID_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_NETWORK_ID_3 = CFG_IDX_W'(3);

	localparam logic OP_START   = 1'b0;
	localparam logic OP_SERVICE = 1'b1;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_END   = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	// frame descriptor, stream in the lowest bits when packed
	typedef struct packed {
		logic                done;
		logic [CNT_W-1:0]    count;
		logic [ADDR_W-1:0]   addr;
		logic [NODE_W-1:0]   node;
		logic [STREAM_W-1:0] stream;
	} frame_t;

endpackage

// File: rtl/round_robin_frame_segmenter_unit.sv
// Round-robin frame segmenter: per-stream transfer state and frame sequencer.

// Holds one pending transmit transfer per stream (base address, length, bytes
// sent). A start word (s_tuser = 0) loads one stream and produces no output.
// A service word (s_tuser = 1) walks up to ROUNDS rounds; each round visits
// streams 0..STREAMS-1 in order, one stream per cycle while the output is not
// stalled, and a stream with bytes left emits a frame descriptor of up to 8
// bytes. The pass ends early after a round in which nothing was sent. If the
// final frame did not complete its transfer, a flush marker (m_tuser = 1)
// follows; m_tlast marks the final word of every pass that emits output. A
// service pass visits every stream of each round it reaches, then closes in
// ST_END and, if needed, ST_FLUSH, and lasts longer while the output is
// stalled; the limit is the single subtract/compare/add unit, which serves
// one stream per cycle. s_tready is high only between passes. Each frame is
// held one step before it is sent, so that m_tlast can be set on it. Config
// writes to network_id_0..3 (cfg_index 0..3) are always accepted; other
// indexes are ignored. No memories need clearing after reset.
module round_robin_frame_segmenter_unit #(
	parameter int STREAMS = rrfs_pkg::STREAMS_DEF,
	parameter int ROUNDS  = rrfs_pkg::ROUNDS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [1:0] stream, [33:2] buffer_address, [49:34] length, zero fill
	input  logic [rrfs_pkg::IN_DATA_W-1:0]     s_tdata,
	// [0] op
	input  logic                               s_tuser,
	// output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [1:0] stream_out, [9:2] node_id, [41:10] frame_address,
	// [45:42] byte_count, [46] transfer_done, zero fill
	output logic [rrfs_pkg::OUT_DATA_W-1:0]    m_tdata,
	// [0] kind
	output logic                               m_tuser,
	output logic                               m_tlast,
	// config write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rrfs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rrfs_pkg::NODE_W-1:0]        cfg_data
);
	import rrfs_pkg::*;

	localparam int IW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

	// per-stream transfer state
	logic [LEN_W-1:0]  len_q  [STREAMS];
	logic [LEN_W-1:0]  sent_q [STREAMS];
	logic [ADDR_W-1:0] base_q [STREAMS];
	logic [NODE_W-1:0] nid_q  [NUM_IDS];

	// sequencer
	logic [1:0]          state_q;
	logic [STREAM_W-1:0] s_q;
	logic [RW-1:0]       round_q;
	logic                any_q;

	// frame waiting for its successor to settle tlast
	frame_t held_q;
	logic   held_vld_q;

	// output register
	frame_t out_q;
	logic   out_vld_q;
	logic   out_kind_q;
	logic   out_last_q;

	// input fields
	logic                in_op;
	logic [STREAM_W-1:0] in_stream;
	logic [ADDR_W-1:0]   in_addr;
	logic [LEN_W-1:0]    in_len;
	logic                in_ok;

	assign in_op     = s_tuser;
	assign in_stream = s_tdata[STREAM_W-1:0];
	assign in_addr   = s_tdata[STREAM_W+ADDR_W-1:STREAM_W];
	assign in_len    = s_tdata[STREAM_W+ADDR_W+LEN_W-1:STREAM_W+ADDR_W];
	assign in_ok     = ({30'd0, in_stream} < 32'(STREAMS));

	// shared frame unit: works on the stream under the cursor
	logic [IW-1:0]     sel;
	logic [LEN_W-1:0]  cur_len, cur_sent, rem;
	logic [CNT_W-1:0]  n;
	logic              active, fits;
	frame_t            frame;

	assign sel      = IW'(s_q);
	assign cur_len  = len_q[sel];
	assign cur_sent = sent_q[sel];
	assign active   = (cur_sent != cur_len);
	assign rem      = cur_len - cur_sent;
	assign fits     = (rem <= LEN_W'(FRAME_MAX));
	assign n        = fits ? rem[CNT_W-1:0] : CNT_W'(FRAME_MAX);

	always_comb begin
		frame.stream = s_q;
		frame.node   = nid_q[s_q];
		frame.addr   = base_q[sel] + {{(ADDR_W-LEN_W){1'b0}}, cur_sent};
		frame.count  = n;
		frame.done   = fits;
	end

	logic out_free, in_acc, last_stream, last_round;

	assign out_free    = !out_vld_q || m_tready;
	assign s_tready    = (state_q == ST_IDLE);
	assign in_acc      = s_tvalid && s_tready;
	assign last_stream = ({30'd0, s_q} == 32'(STREAMS - 1));
	assign last_round  = (round_q == RW'(ROUNDS - 1));

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_IDS; i++) nid_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < NUM_IDS; i++)
				if (cfg_index == CFG_IDX_W'(i)) nid_q[i] <= cfg_data;
		end
	end

	// transfer state: loaded by start words, advanced by the frame unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STREAMS; i++) begin
				len_q[i]  <= '0;
				sent_q[i] <= '0;
				base_q[i] <= '0;
			end
		end else if (in_acc && in_op == OP_START && in_ok) begin
			len_q[IW'(in_stream)]  <= in_len;
			sent_q[IW'(in_stream)] <= '0;
			base_q[IW'(in_stream)] <= in_addr;
		end else if (state_q == ST_SCAN && out_free && active) begin
			sent_q[sel] <= cur_sent + {{(LEN_W-CNT_W){1'b0}}, n};
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			s_q        <= '0;
			round_q    <= '0;
			any_q      <= 1'b0;
			held_q     <= '0;
			held_vld_q <= 1'b0;
			out_q      <= '0;
			out_vld_q  <= 1'b0;
			out_kind_q <= KIND_FRAME;
			out_last_q <= 1'b0;
		end else begin
			if (out_vld_q && m_tready) out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_op == OP_SERVICE) begin
						state_q    <= ST_SCAN;
						s_q        <= '0;
						round_q    <= '0;
						any_q      <= 1'b0;
						held_vld_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (out_free) begin
						if (active) begin
							held_q     <= frame;
							held_vld_q <= 1'b1;
							if (held_vld_q) begin
								out_q      <= held_q;
								out_kind_q <= KIND_FRAME;
								out_last_q <= 1'b0;
								out_vld_q  <= 1'b1;
							end
						end
						if (last_stream) begin
							// a round with nothing sent ends the pass
							if (!(any_q || active) || last_round) begin
								state_q <= ST_END;
							end else begin
								round_q <= round_q + RW'(1);
								s_q     <= '0;
								any_q   <= 1'b0;
							end
						end else begin
							s_q   <= s_q + STREAM_W'(1);
							any_q <= any_q || active;
						end
					end
				end
				ST_END: begin
					if (out_free) begin
						if (held_vld_q) begin
							out_q      <= held_q;
							out_kind_q <= KIND_FRAME;
							out_last_q <= held_q.done;
							out_vld_q  <= 1'b1;
							held_vld_q <= 1'b0;
							state_q    <= held_q.done ? ST_IDLE : ST_FLUSH;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_q      <= '0;
						out_kind_q <= KIND_FLUSH;
						out_last_q <= 1'b1;
						out_vld_q  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_DATA_W-$bits(frame_t)){1'b0}}, out_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	// a flush marker always closes its pass
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_kind_q == KIND_FLUSH) |-> out_last_q)
		else $error("flush marker without tlast");

	// frame descriptors carry 1..8 bytes
	a_frame_size: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_kind_q == KIND_FRAME) |->
		(out_q.count != '0 && out_q.count <= CNT_W'(FRAME_MAX)))
		else $error("frame byte count out of range");

	// an unfinished final frame is followed by a flush
	a_flush_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_END && out_free && held_vld_q && !held_q.done) |=>
		(state_q == ST_FLUSH))
		else $error("missing flush after unfinished frame");

	// the cursor stream never overshoots its transfer
	a_sent_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_sent <= cur_len)
		else $error("sent count beyond transfer length");

	// no new item while a pass is in its scan state
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !s_tready)
		else $error("input accepted during a service pass");

endmodule
